@@ sv/assert_macros.svh @@
// Assertion macros shared by the signed value to digit writes block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SVDW_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SVDW_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/svdw_pkg.sv @@
// Shared constants and types of the signed value to digit writes block.
package svdw_pkg;

	localparam int VALUE_W            = 16;
	localparam int POS_W              = 3;
	localparam int CODE_W             = 4;
	localparam int DISPLAY_DIGITS_DEF = 4;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [CODE_W-1:0] MINUS_CODE = 4'd10;

	// Reciprocal of ten: floor(x * 52429 / 2**19) == x / 10 for x below 43699
	localparam logic [16:0] DIV10_MAGIC = 17'd52429;
	localparam int          DIV10_SHIFT = 19;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/svdw_front.sv @@
// Front end: accepts a value, splits its magnitude into decimal digit codes.
module svdw_front
	import svdw_pkg::*;
#(
	parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [VALUE_W-1:0]              value,
	output logic                                   busy,
	input  q_stat_t                                q_stat,
	output logic                                   push,
	output logic [DISPLAY_DIGITS-1:0][CODE_W-1:0]  push_codes
);

	localparam int IW   = $clog2(DISPLAY_DIGITS);
	localparam int KEEP = DISPLAY_DIGITS - 1;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CONV = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]                             state_q;
	logic [VALUE_W-1:0]                     mag_q;
	logic                                   neg_q;
	logic [IW-1:0]                          cnt_q;
	logic [DISPLAY_DIGITS-1:0][CODE_W-1:0]  codes_q;

	logic                                   accept;
	logic [VALUE_W-1:0]                     value_u;
	logic [VALUE_W-1:0]                     mag_in;
	logic [32:0]                            prod;
	logic [VALUE_W-1:0]                     quot;
	logic [VALUE_W-1:0]                     tens;
	logic [VALUE_W-1:0]                     rem;
	logic                                   conv_last;
	logic [IW-1:0]                          minus_idx;
	logic [DISPLAY_DIGITS-1:0][CODE_W-1:0]  codes_conv;

	assign accept  = start && (state_q == F_IDLE);
	assign busy    = (state_q != F_IDLE);
	assign value_u = $unsigned(value);

	// Take magnitude; the most negative value maps to 16'h8000
	assign mag_in = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;

	// Divide by ten through the reciprocal, then form the remainder
	assign prod      = 33'(mag_q) * 33'(DIV10_MAGIC);
	assign quot      = VALUE_W'(prod[32:DIV10_SHIFT]);
	assign tens      = (quot << 3) + (quot << 1);
	assign rem       = mag_q - tens;
	assign conv_last = (quot == '0) || (cnt_q == IW'(KEEP - 1));
	assign minus_idx = IW'({1'b0, cnt_q} + (IW+1)'(1));

	assign push       = (state_q == F_PUSH) && !q_stat.full;
	assign push_codes = codes_q;

	// Merge the new digit and, on the last digit of a negative value, the minus sign
	always_comb begin
		codes_conv        = codes_q;
		codes_conv[cnt_q] = rem[CODE_W-1:0];
		if (conv_last && neg_q) begin
			codes_conv[minus_idx] = MINUS_CODE;
		end
	end

	// Sequence the conversion and the hand-off to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= '0;
					end
				end
				F_CONV: begin
					if (conv_last) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= IW'({1'b0, cnt_q} + (IW+1)'(1));
					end
				end
				F_PUSH: begin
					if (!q_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Hold magnitude, sign and digit codes of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= mag_in;
			neg_q   <= value_u[VALUE_W-1];
			codes_q <= '0;
		end else if (state_q == F_CONV) begin
			mag_q   <= quot;
			codes_q <= codes_conv;
		end
	end

endmodule

@@ sv/svdw_queue.sv @@
// Short queue of converted digit sets between front and back ends.
module svdw_queue
	import svdw_pkg::*;
#(
	parameter int WIDTH = DISPLAY_DIGITS_DEF * CODE_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output q_stat_t          q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign q_stat.full  = (count_q == (PW+1)'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rd_data      = data_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ sv/svdw_back.sv @@
// Back end: emits one driver register write per digit position.
module svdw_back
	import svdw_pkg::*;
#(
	parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  q_stat_t                                q_stat,
	input  logic [DISPLAY_DIGITS-1:0][CODE_W-1:0]  pop_codes,
	output logic                                   pop,
	output logic                                   strobe,
	output logic [POS_W-1:0]                       digit_position,
	output logic [CODE_W-1:0]                      digit_code,
	output logic                                   last_write
);

	localparam int IW = $clog2(DISPLAY_DIGITS);

	logic                                   active_q;
	logic [IW-1:0]                          idx_q;
	logic [DISPLAY_DIGITS-1:0][CODE_W-1:0]  cur_q;

	logic          at_last;
	logic [IW:0]   pos_w;

	assign at_last = (idx_q == IW'(DISPLAY_DIGITS - 1));
	assign pop     = !q_stat.empty && (!active_q || at_last);
	assign pos_w   = {1'b0, idx_q} + (IW+1)'(1);

	assign strobe         = active_q;
	assign digit_position = POS_W'(pos_w);
	assign digit_code     = cur_q[idx_q];
	assign last_write     = active_q && at_last;

	// Step through the positions; chain straight into the next queued set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q && at_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= IW'(pos_w);
			end
		end
	end

	// Hold the digit set being written
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_codes;
		end
	end

endmodule

@@ sv/signed_value_to_digit_writes.sv @@
// Top level: signed value to display driver digit writes.
//
//  channel   direction  handshake                    payload
//  command   in         start && !busy               value
//  result    out        strobe (one cycle, no stall) digit_position, digit_code, last_write
//
// Busy stays high for one divide-by-ten step per kept digit (one to
// DISPLAY_DIGITS - 1) plus a hand-off that waits while the queue is full,
// then drops in the idle state, where the next value is accepted.
// The back emits DISPLAY_DIGITS writes per value on consecutive cycles, and the
// front can accept and convert the next value while those writes run, as the
// queue holds up to QUEUE_DEPTH converted sets. Reset clears all control state.
`include "assert_macros.svh"

module signed_value_to_digit_writes
	import svdw_pkg::*;
#(
	parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      busy,
	output logic                      strobe,
	output logic [POS_W-1:0]          digit_position,
	output logic [CODE_W-1:0]         digit_code,
	output logic                      last_write
);

	localparam int SET_W = DISPLAY_DIGITS * CODE_W;

	q_stat_t                               q_stat;
	logic                                  q_push;
	logic                                  q_pop;
	logic [DISPLAY_DIGITS-1:0][CODE_W-1:0] wr_codes;
	logic [DISPLAY_DIGITS-1:0][CODE_W-1:0] rd_codes;

	svdw_front #(
		.DISPLAY_DIGITS(DISPLAY_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_codes(wr_codes)
	);

	svdw_queue #(
		.WIDTH(SET_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(wr_codes),
		.pop    (q_pop),
		.rd_data(rd_codes),
		.q_stat (q_stat)
	);

	svdw_back #(
		.DISPLAY_DIGITS(DISPLAY_DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop_codes     (rd_codes),
		.pop           (q_pop),
		.strobe        (strobe),
		.digit_position(digit_position),
		.digit_code    (digit_code),
		.last_write    (last_write)
	);

	// Check front, queue and write sequencer cooperation
	`SVDW_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted value did not raise busy")
	`SVDW_ASSERT_SAME(a_no_push_full, clk, arst_n, q_push, !q_stat.full, "push into a full queue")
	`SVDW_ASSERT_NEXT(a_run_unbroken, clk, arst_n, strobe && !last_write, strobe, "write run broke off early")
	`SVDW_ASSERT_NEXT(a_pos_step, clk, arst_n, strobe && !last_write, digit_position == POS_W'($past(digit_position) + 1'b1), "digit position did not step")

endmodule

@@ verif/signed_value_to_digit_writes_test.sv @@
// Self-checking testbench for the signed value to digit writes block.
`timescale 1ns / 100ps

module signed_value_to_digit_writes_test
	import svdw_pkg::*;
();

	localparam int DIGITS      = DISPLAY_DIGITS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_ITEMS = 400;

	typedef logic [DIGITS-1:0][CODE_W-1:0] code_vec_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CODE_W-1:0] code;
		logic              last;
	} digit_write_t;

	// One directed row; codes are listed from the top position down to position 1
	typedef struct packed {
		logic signed [VALUE_W-1:0] v;
		logic                      typed;
		code_vec_t                 codes;
	} stim_row_t;

	localparam int ROWS = 21;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic signed [VALUE_W-1:0] value;
	logic                      busy;
	logic                      strobe;
	logic [POS_W-1:0]          digit_position;
	logic [CODE_W-1:0]         digit_code;
	logic                      last_write;

	// Typed expectation travels with the transaction
	logic      typed_row;
	code_vec_t typed_codes;

	digit_write_t pending_writes[$];
	digit_write_t next_write;
	code_vec_t    accepted_codes;
	int           mismatch_count;
	int           stall_cycles;
	int           idle_pct;

	stim_row_t stim_rows [ROWS] = '{
		'{16'sd0,      1'b1, {4'd0, 4'd0, 4'd0, 4'd0}},
		'{16'sd1,      1'b0, '0},
		'{-16'sd1,     1'b1, {4'd0, 4'd0, MINUS_CODE, 4'd1}},
		'{16'sd9,      1'b0, '0},
		'{-16'sd9,     1'b0, '0},
		'{16'sd10,     1'b0, '0},
		'{-16'sd10,    1'b0, '0},
		'{16'sd99,     1'b0, '0},
		'{-16'sd99,    1'b0, '0},
		'{16'sd100,    1'b0, '0},
		'{-16'sd100,   1'b0, '0},
		'{16'sd999,    1'b1, {4'd0, 4'd9, 4'd9, 4'd9}},
		'{-16'sd999,   1'b1, {MINUS_CODE, 4'd9, 4'd9, 4'd9}},
		'{16'sd1000,   1'b0, '0},
		'{-16'sd1000,  1'b0, '0},
		'{16'sd32767,  1'b1, {4'd0, 4'd7, 4'd6, 4'd7}},
		'{16'sh8000,   1'b1, {MINUS_CODE, 4'd7, 4'd6, 4'd8}},
		'{16'sd12345,  1'b0, '0},
		'{-16'sd12345, 1'b0, '0},
		'{16'sh5555,   1'b0, '0},
		'{16'shAAAA,   1'b0, '0}
	};

	signed_value_to_digit_writes u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.value          (value),
		.busy           (busy),
		.strobe         (strobe),
		.digit_position (digit_position),
		.digit_code     (digit_code),
		.last_write     (last_write)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Split the magnitude into kept decimal digits, minus sign just above them
	function automatic code_vec_t expected_codes(input logic signed [VALUE_W-1:0] v);
		code_vec_t        codes;
		logic [VALUE_W:0] mag;
		int               used;
		codes = '0;
		mag = v[VALUE_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
		used = 0;
		do begin
			codes[used] = CODE_W'(mag % 10);
			mag = mag / 10;
			used++;
		end while (mag != 0 && used < DIGITS - 1);
		if (v[VALUE_W-1])
			codes[used] = MINUS_CODE;
		return codes;
	endfunction

	// Mix full-range values with short magnitudes and the extremes
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int kind;
		kind = $urandom_range(9);
		if (kind < 5)
			return VALUE_W'($urandom);
		else if (kind < 8)
			return VALUE_W'(int'($urandom_range(2000)) - 1000);
		else if (kind == 8)
			return VALUE_W'(int'($urandom_range(198)) - 99);
		else begin
			case ($urandom_range(3))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'shFFFF;
				default: return 16'sh0000;
			endcase
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic typed,
			input code_vec_t codes);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		value       <= v;
		typed_row   <= typed;
		typed_codes <= codes;
		do @(posedge clk); while (busy);
	endtask

	// Record accepted values and check every write strobe
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			accepted_codes = typed_row ? typed_codes : expected_codes(value);
			for (int i = 0; i < DIGITS; i++)
				pending_writes.push_back('{POS_W'(i + 1), accepted_codes[i], i == DIGITS - 1});
		end
		if (arst_n && strobe) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write pos %0d code %0d last %0b",
					digit_position, digit_code, last_write));
			end else begin
				next_write = pending_writes.pop_front();
				if (digit_position !== next_write.pos)
					report_mismatch($sformatf("digit_position %0d, expected %0d",
						digit_position, next_write.pos));
				if (digit_code !== next_write.code)
					report_mismatch($sformatf("digit_code %0d at pos %0d, expected %0d",
						digit_code, next_write.pos, next_write.code));
				if (last_write !== next_write.last)
					report_mismatch($sformatf("last_write %0b at pos %0d, expected %0b",
						last_write, next_write.pos, next_write.last));
			end
		end
	end

	// Abort when neither side moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", stall_cycles);
			$display("signed_value_to_digit_writes test failed");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		stall_cycles   = 0;
		idle_pct       = 27;
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		typed_row      = 1'b0;
		typed_codes    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int r = 0; r < ROWS; r++)
			send_value(stim_rows[r].v, stim_rows[r].typed, stim_rows[r].codes);

		// Random values: light sender gaps, heavy gaps, then back to back
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3)
				idle_pct = 88;
			else if (n == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			send_value(pick_value(), 1'b0, '0);
		end
		start <= 1'b0;
		@(posedge clk);

		// Drain outstanding writes, then watch for strays
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_writes.size() == 0)
			$display("signed_value_to_digit_writes test passed");
		else
			$display("signed_value_to_digit_writes test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/svdw_pkg.sv
sv/svdw_front.sv
sv/svdw_queue.sv
sv/svdw_back.sv
sv/signed_value_to_digit_writes.sv
verif/signed_value_to_digit_writes_test.sv
